>>> sv/ngq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngq_pkg - shared types and constants of the note grid quantizer
// Field widths, register indexes, sequencer states and the control bundle of
// the serial remainder unit.
// ----------------------------------------------------------------------------
package ngq_pkg;

   localparam int PITCH_W    = 7;
   localparam int RAW_W      = 32;
   localparam int TICK_W     = 33;
   localparam int WIDE_W     = 34;
   localparam int GRID_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_CNT_W = 6;

   localparam int DEF_PITCH_COUNT       = 128;
   localparam int DEF_TICKS_PER_QUARTER = 960;

   localparam logic [TICK_W-1:0]     TICK_MAX  = {TICK_W{1'b1}};
   localparam logic [STEP_CNT_W-1:0] DIV_STEPS = STEP_CNT_W'(TICK_W);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SNAP_SUB,
      ST_SNAP_ADD,
      ST_FIX_A,
      ST_PUSH,
      ST_FIX_B,
      ST_SAT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } rem_ctl_type;

endpackage
`default_nettype wire

>>> sv/ngq_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ngq_rem - bit-serial remainder
// Takes the dividend one bit per cycle while shift is set, MSB first, and keeps the running
// remainder modulo the grid.
// ----------------------------------------------------------------------------
module ngq_rem (
   input  wire logic                             clock,
   input  wire ngq_pkg::rem_ctl_type             ctl,
   input  wire logic                             bit_in,
   input  wire logic [ngq_pkg::GRID_W-1:0]       divisor,
   output logic      [ngq_pkg::GRID_W-1:0]       rem
);

   logic [ngq_pkg::GRID_W-1:0] rem_ff, rem_in;
   logic [ngq_pkg::GRID_W:0]   trial;

   always_comb begin
      trial  = {rem_ff, bit_in};
      rem_in = rem_ff;
      if (ctl.clear) begin
         rem_in = '0;
      end else if (ctl.shift) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = ngq_pkg::GRID_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[ngq_pkg::GRID_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign rem = rem_ff;

endmodule
`default_nettype wire

>>> sv/note_grid_quantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// note_grid_quantizer - snaps note pairs to a tick grid
// Drops short pairs, fills in missing ends, rounds both ends to the grid and
// pushes a start up to the last end of the same pitch.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall pitch, start/end tick, flags
//   rsp      out        rsp_valid/rsp_stall pitch, start, end
//   csr      in         csr_we              index, 16-bit data
//
// With a grid, a beat runs through the accept cycle, the serial remainder
// of both ticks (one bit a cycle), then 7 fixup steps. Without a grid, the
// remainder and both snap steps are skipped. A dropped pair gives no result
// and the unit stays idle. One beat is in work at a time; the result
// register lets the next beat in while a result waits on rsp_stall.
// Reset is synchronous; the pitch table holds nothing valid after it.
// ----------------------------------------------------------------------------
module note_grid_quantizer #(
   parameter int PITCH_COUNT       = ngq_pkg::DEF_PITCH_COUNT,
   parameter int TICKS_PER_QUARTER = ngq_pkg::DEF_TICKS_PER_QUARTER
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ngq_pkg::PITCH_W-1:0]        req_pitch,
   input  wire logic [ngq_pkg::RAW_W-1:0]          req_start_tick,
   input  wire logic [ngq_pkg::RAW_W-1:0]          req_end_tick,
   input  wire logic                               req_has_end,
   input  wire logic                               req_new_take,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [ngq_pkg::PITCH_W-1:0]        rsp_out_pitch,
   output logic      [ngq_pkg::TICK_W-1:0]         rsp_out_start,
   output logic      [ngq_pkg::TICK_W-1:0]         rsp_out_end,
   input  wire logic                               csr_we,
   input  wire logic [ngq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ngq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
   localparam logic [ngq_pkg::PITCH_W:0] PITCH_LIMIT = (ngq_pkg::PITCH_W+1)'(PITCH_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PITCH_COUNT - 1);
   localparam logic [ngq_pkg::GRID_W-1:0] DEF_LEN = ngq_pkg::GRID_W'(TICKS_PER_QUARTER / 4);
   localparam int TW = ngq_pkg::TICK_W;
   localparam int WW = ngq_pkg::WIDE_W;

   ngq_pkg::state_type state_ff, state_in;

   logic [ngq_pkg::GRID_W-1:0]     grid_ff, min_len_ff;
   logic [ngq_pkg::PITCH_W-1:0]    pitch_ff, pitch_in;
   logic [IDX_W-1:0]               idx_ff, idx_in, req_idx;
   logic                           hit_ff, hit_in;
   logic [WW-1:0]                  on_ff, on_in, off_ff, off_in;
   logic [ngq_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           up_on_ff, up_on_in, up_off_ff, up_off_in;
   logic [TW-1:0]                  last_ff;
   logic [PITCH_COUNT-1:0]         valid_ff;
   logic [TW-1:0]                  table_mem [PITCH_COUNT];

   logic                           rsp_valid_ff;
   logic [ngq_pkg::PITCH_W-1:0]    rsp_pitch_ff;
   logic [TW-1:0]                  rsp_start_ff, rsp_end_ff;

   ngq_pkg::rem_ctl_type           rem_ctl;
   logic [ngq_pkg::GRID_W-1:0]     rem_on, rem_off;

   logic            accept, load, drop, out_free;
   logic [TW-1:0]   raw_len, on_fin;
   logic [WW-1:0]   step, off_init;
   logic [ngq_pkg::GRID_W-1:0] dur;

   assign req_stall = (state_ff != ngq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_idx = ({1'b0, req_pitch} < PITCH_LIMIT) ? req_pitch[IDX_W-1:0] : LAST_IDX;

   assign raw_len  = {1'b0, req_end_tick} - {1'b0, req_start_tick};
   assign drop     = req_has_end && (min_len_ff != '0) &&
                     (raw_len[TW-1] || (raw_len[ngq_pkg::RAW_W-1:0] <
                      {{(ngq_pkg::RAW_W-ngq_pkg::GRID_W){1'b0}}, min_len_ff}));
   assign dur      = (grid_ff != '0) ? grid_ff : DEF_LEN;
   assign off_init = req_has_end ? {2'b00, req_end_tick}
                                 : {2'b00, req_start_tick} + {{(WW-ngq_pkg::GRID_W){1'b0}}, dur};
   assign step     = (grid_ff != '0) ? {{(WW-ngq_pkg::GRID_W){1'b0}}, grid_ff} : WW'(1);
   assign on_fin   = (on_ff >= off_ff) ? TW'(off_ff - WW'(1)) : on_ff[TW-1:0];

   ngq_rem u_rem_on (
      .clock   (clock),
      .ctl     (rem_ctl),
      .bit_in  (on_ff[TW-1]),
      .divisor (grid_ff),
      .rem     (rem_on)
   );

   ngq_rem u_rem_off (
      .clock   (clock),
      .ctl     (rem_ctl),
      .bit_in  (off_ff[TW-1]),
      .divisor (grid_ff),
      .rem     (rem_off)
   );

   always_comb begin
      state_in  = state_ff;
      pitch_in  = pitch_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      on_in     = on_ff;
      off_in    = off_ff;
      cnt_in    = cnt_ff;
      up_on_in  = up_on_ff;
      up_off_in = up_off_ff;
      rem_ctl   = '0;
      load      = 1'b0;
      case (state_ff)
         ngq_pkg::ST_IDLE: begin
            if (req_valid) begin
               pitch_in      = req_pitch;
               idx_in        = req_idx;
               hit_in        = !req_new_take && valid_ff[req_idx];
               on_in         = {2'b00, req_start_tick};
               off_in        = off_init;
               cnt_in        = ngq_pkg::DIV_STEPS;
               rem_ctl.clear = 1'b1;
               if (!drop) begin
                  state_in = (grid_ff != '0) ? ngq_pkg::ST_DIV : ngq_pkg::ST_FIX_A;
               end
            end
         end
         ngq_pkg::ST_DIV: begin
            // rotate so the tick is back in place after the last bit
            rem_ctl.shift = 1'b1;
            on_in  = {on_ff[WW-1:TW], on_ff[TW-2:0], on_ff[TW-1]};
            off_in = {off_ff[WW-1:TW], off_ff[TW-2:0], off_ff[TW-1]};
            cnt_in = cnt_ff - ngq_pkg::STEP_CNT_W'(1);
            if (cnt_ff == ngq_pkg::STEP_CNT_W'(1)) begin
               state_in = ngq_pkg::ST_SNAP_SUB;
            end
         end
         ngq_pkg::ST_SNAP_SUB: begin
            on_in     = on_ff - {{(WW-ngq_pkg::GRID_W){1'b0}}, rem_on};
            off_in    = off_ff - {{(WW-ngq_pkg::GRID_W){1'b0}}, rem_off};
            up_on_in  = ({rem_on, 1'b0} >= {1'b0, grid_ff});
            up_off_in = ({rem_off, 1'b0} >= {1'b0, grid_ff});
            state_in  = ngq_pkg::ST_SNAP_ADD;
         end
         ngq_pkg::ST_SNAP_ADD: begin
            if (up_on_ff) begin
               on_in = on_ff + step;
            end
            if (up_off_ff) begin
               off_in = off_ff + step;
            end
            state_in = ngq_pkg::ST_FIX_A;
         end
         ngq_pkg::ST_FIX_A: begin
            if (off_ff <= on_ff) begin
               off_in = on_ff + step;
            end
            state_in = ngq_pkg::ST_PUSH;
         end
         ngq_pkg::ST_PUSH: begin
            if (hit_ff && (on_ff < {1'b0, last_ff})) begin
               on_in = {1'b0, last_ff};
            end
            state_in = ngq_pkg::ST_FIX_B;
         end
         ngq_pkg::ST_FIX_B: begin
            if (off_ff <= on_ff) begin
               off_in = on_ff + step;
            end
            state_in = ngq_pkg::ST_SAT;
         end
         ngq_pkg::ST_SAT: begin
            if (off_ff > {1'b0, ngq_pkg::TICK_MAX}) begin
               off_in = {1'b0, ngq_pkg::TICK_MAX};
            end
            state_in = ngq_pkg::ST_FIN;
         end
         ngq_pkg::ST_FIN: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ngq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ngq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ngq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff  <= pitch_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      on_ff     <= on_in;
      off_ff    <= off_in;
      cnt_ff    <= cnt_in;
      up_on_ff  <= up_on_in;
      up_off_ff <= up_off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff    <= '0;
         min_len_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ngq_pkg::CSR_GRID:    grid_ff    <= csr_wdata;
            ngq_pkg::CSR_MIN_LEN: min_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (accept && req_new_take) begin
            valid_ff <= '0;
         end
         if (load) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         table_mem[idx_ff] <= off_ff[TW-1:0];
      end
      if (accept) begin
         last_ff <= table_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_pitch_ff <= pitch_ff;
         rsp_start_ff <= on_fin;
         rsp_end_ff   <= off_ff[TW-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pitch = rsp_pitch_ff;
   assign rsp_out_start = rsp_start_ff;
   assign rsp_out_end   = rsp_end_ff;

   a_end_after_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_end_ff > rsp_start_ff))
      else $error("result end not after start");

   a_div_needs_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ngq_pkg::ST_DIV) |-> (grid_ff != '0))
      else $error("serial remainder running with zero grid");

   a_table_marked: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff[$past(idx_ff)])
      else $error("pitch entry not marked after write");

endmodule
`default_nettype wire
